// ===== src/gf16mac_pkg.sv =====
package gf16mac_pkg;

    localparam int MAX_SOURCES = 8;
    localparam int NUM_LANES   = MAX_SOURCES;
    localparam int WORD_W      = 16;
    localparam int HALF_W      = WORD_W / 2;
    localparam int PROD_W      = 2 * WORD_W - 1;
    localparam int CNT_W       = 4;
    localparam int NUM_REGS    = 8;
    localparam int IDX_W       = $clog2(NUM_REGS);
    localparam int ADDR_W      = IDX_W + 2;
    localparam int APB_W       = 32;

    localparam logic [WORD_W:0]   GF_POLY = 17'h1100b;
    localparam logic [WORD_W-1:0] GF_TAIL = GF_POLY[WORD_W-1:0];

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [IDX_W-1:0]  t_idx;

    typedef struct packed {
        logic adv1;
        logic adv2;
    } t_lane_ctl;

    function automatic logic [2*HALF_W-2:0] clmul_half(
        input logic [HALF_W-1:0] a,
        input logic [HALF_W-1:0] b
    );
        logic [2*HALF_W-2:0] acc;
        acc = '0;
        for (int i = 0; i < HALF_W; i++) begin
            if (b[i]) begin
                acc = acc ^ ((2*HALF_W-1)'(a) << i);
            end
        end
        return acc;
    endfunction

    function automatic logic [WORD_W:0] barrett_mu();
        logic [2*WORD_W:0] rem;
        logic [WORD_W:0]   q;
        rem = '0;
        rem[2*WORD_W] = 1'b1;
        q = '0;
        for (int b = 2 * WORD_W; b >= WORD_W; b--) begin
            if (rem[b]) begin
                q[b-WORD_W] = 1'b1;
                rem = rem ^ ((2*WORD_W+1)'(GF_POLY) << (b - WORD_W));
            end
        end
        return q;
    endfunction

    localparam logic [WORD_W:0] GF_MU = barrett_mu();

    function automatic t_word gf_reduce(input t_prod p);
        logic [WORD_W-2:0]   hi;
        logic [2*WORD_W-1:0] hm;
        logic [WORD_W-2:0]   q;
        logic [2*WORD_W-1:0] qg;
        hi = p[PROD_W-1:WORD_W];
        hm = '0;
        for (int i = 0; i <= WORD_W; i++) begin
            if (GF_MU[i]) begin
                hm = hm ^ ((2*WORD_W)'(hi) << i);
            end
        end
        q = hm[PROD_W-1:WORD_W];
        qg = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (GF_TAIL[i]) begin
                qg = qg ^ ((2*WORD_W)'(q) << i);
            end
        end
        return p[WORD_W-1:0] ^ qg[WORD_W-1:0];
    endfunction

endpackage

// ===== src/gf16mac_lane.sv =====
module gf16mac_lane (
    input  logic                  i_clk,
    input  gf16mac_pkg::t_lane_ctl i_ctl,
    input  logic                  i_act,
    input  gf16mac_pkg::t_word    i_coef,
    input  gf16mac_pkg::t_word    i_word,
    output gf16mac_pkg::t_word    o_prod
);

    localparam int H = gf16mac_pkg::HALF_W;
    localparam int W = gf16mac_pkg::WORD_W;
    localparam int P = gf16mac_pkg::PROD_W;

    logic [2*H-2:0]        w_hh;
    logic [2*H-2:0]        w_ll;
    logic [2*H-2:0]        w_mm;
    logic [2*H-2:0]        w_mid;
    gf16mac_pkg::t_word    w_word;
    gf16mac_pkg::t_prod    n_prod;
    gf16mac_pkg::t_prod    r_prod;
    gf16mac_pkg::t_word    r_red;

    assign w_word = i_act ? i_word : '0;
    assign w_hh   = gf16mac_pkg::clmul_half(i_coef[W-1:H], w_word[W-1:H]);
    assign w_ll   = gf16mac_pkg::clmul_half(i_coef[H-1:0], w_word[H-1:0]);
    assign w_mm   = gf16mac_pkg::clmul_half(i_coef[W-1:H] ^ i_coef[H-1:0],
                                            w_word[W-1:H] ^ w_word[H-1:0]);
    assign w_mid  = w_mm ^ w_hh ^ w_ll;
    assign n_prod = (P'(w_hh) << W) ^ (P'(w_mid) << H) ^ P'(w_ll);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv1) begin
            r_prod <= n_prod;
        end
        if (i_ctl.adv2) begin
            r_red <= gf16mac_pkg::gf_reduce(r_prod);
        end
    end

    assign o_prod = r_red;

endmodule

// ===== src/gf16mac_merge.sv =====
module gf16mac_merge (
    input  logic               i_clk,
    input  logic               i_adv,
    input  gf16mac_pkg::t_word i_prod [gf16mac_pkg::NUM_LANES],
    input  gf16mac_pkg::t_word i_accum,
    input  logic               i_block_end,
    output gf16mac_pkg::t_word o_accum,
    output logic               o_block_end
);

    gf16mac_pkg::t_word n_accum;
    gf16mac_pkg::t_word r_accum;
    logic               r_block_end;

    always_comb begin
        n_accum = i_accum;
        for (int i = 0; i < gf16mac_pkg::NUM_LANES; i++) begin
            n_accum = n_accum ^ i_prod[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_accum     <= n_accum;
            r_block_end <= i_block_end;
        end
    end

    assign o_accum     = r_accum;
    assign o_block_end = r_block_end;

endmodule

// ===== src/gf16_multiply_accumulate_unit.sv =====
// Pipeline: an accepted item is registered in the multiply stage, then the reduce stage,
// then the merge stage, whose register drives the result and o_valid.
// Throughput: one item per cycle while the output accepts results; each pipeline stage
// moves on when the next one is empty or moving, so a bubble absorbs a stalled result.
// Reset: synchronous active-low; clears stage valid flags and all coefficients
// to zero.
module gf16_multiply_accumulate_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gf16mac_pkg::ADDR_W-1:0]    paddr,
    input  logic [gf16mac_pkg::APB_W-1:0]     pwdata,
    output logic [gf16mac_pkg::APB_W-1:0]     prdata,
    output logic                              pready,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [15:0]                       i_src_word_0,
    input  logic [15:0]                       i_src_word_1,
    input  logic [15:0]                       i_src_word_2,
    input  logic [15:0]                       i_src_word_3,
    input  logic [15:0]                       i_src_word_4,
    input  logic [15:0]                       i_src_word_5,
    input  logic [15:0]                       i_src_word_6,
    input  logic [15:0]                       i_src_word_7,
    input  logic [15:0]                       i_accum_in,
    input  logic [3:0]                        i_active_sources,
    input  logic                              i_block_end,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [15:0]                       o_accum_out,
    output logic                              o_block_end_out
);

    localparam int L = gf16mac_pkg::NUM_LANES;

    gf16mac_pkg::t_word     r_coef [gf16mac_pkg::NUM_REGS];
    gf16mac_pkg::t_word     w_src  [L];
    gf16mac_pkg::t_word     w_prod [L];
    gf16mac_pkg::t_idx      w_idx;
    gf16mac_pkg::t_lane_ctl w_ctl;
    gf16mac_pkg::t_word     r_acc1;
    gf16mac_pkg::t_word     r_acc2;
    logic                   r_be1;
    logic                   r_be2;
    logic                   r_v1;
    logic                   r_v2;
    logic                   r_v3;
    logic                   w_rdy1;
    logic                   w_rdy2;
    logic                   w_rdy3;

    assign w_src[0] = i_src_word_0;
    assign w_src[1] = i_src_word_1;
    assign w_src[2] = i_src_word_2;
    assign w_src[3] = i_src_word_3;
    assign w_src[4] = i_src_word_4;
    assign w_src[5] = i_src_word_5;
    assign w_src[6] = i_src_word_6;
    assign w_src[7] = i_src_word_7;

    assign w_idx  = paddr[gf16mac_pkg::ADDR_W-1:2];
    assign pready = 1'b1;
    assign prdata = gf16mac_pkg::APB_W'(r_coef[w_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < gf16mac_pkg::NUM_REGS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (psel && penable && pwrite && pready) begin
            r_coef[w_idx] <= pwdata[gf16mac_pkg::WORD_W-1:0];
        end
    end

    assign w_rdy3 = !r_v3 || i_ready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    assign w_ctl.adv1 = w_rdy1;
    assign w_ctl.adv2 = w_rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_acc1 <= i_accum_in;
            r_be1  <= i_block_end;
        end
        if (w_rdy2) begin
            r_acc2 <= r_acc1;
            r_be2  <= r_be1;
        end
    end

    for (genvar g = 0; g < L; g++) begin : g_lane
        gf16mac_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_act  (i_active_sources > gf16mac_pkg::t_cnt'(g)),
            .i_coef (r_coef[g]),
            .i_word (w_src[g]),
            .o_prod (w_prod[g])
        );
    end

    gf16mac_merge u_merge (
        .i_clk       (i_clk),
        .i_adv       (w_rdy3),
        .i_prod      (w_prod),
        .i_accum     (r_acc2),
        .i_block_end (r_be2),
        .o_accum     (o_accum_out),
        .o_block_end (o_block_end_out)
    );

    assign o_valid = r_v3;

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v1)
        else $error("accepted transfer not held in first stage");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_v1 && r_v2 && r_v3 && !i_ready)
        else $error("input stalled with a bubble in the pipeline");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_v1 && !r_v2)
        else $error("pipeline not empty after reset");

    a_result_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && w_rdy3 |=> o_valid)
        else $error("reduced item lost before output");

endmodule
